@@ rtl/x128p_pkg.sv @@
// Package: constants and types for the xorshift128+ generator
`timescale 1ns / 1ps
package x128p_pkg;
  localparam int WordW = 64;
  localparam int ShiftA = 23;
  localparam int ShiftB = 18;
  localparam int ShiftC = 5;
  localparam int UnitDrop = 11;
  localparam int UnitBits = 53;
  localparam logic [WordW-1:0] SeedFirstRst = 64'd1;
  localparam logic [WordW-1:0] SeedSecondRst = 64'd2;

  localparam logic [1:0] ModeRaw = 2'd0;
  localparam logic [1:0] ModeRange = 2'd1;
  localparam logic [1:0] ModeUnit = 2'd2;

  localparam logic CfgSeedFirst = 1'b0;
  localparam logic CfgSeedSecond = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_NORM = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;
endpackage

@@ rtl/xorshift128plus_generator_unit.sv @@
// Top level: xorshift128+ generator with raw, range and unit-double modes
// Range mode runs the radix-2 remainder unit; unit mode normalises by a
// one-bit shift per cycle. One transaction in flight at a time.
// Reset (synchronous, rst_n low) sets seeds to 1 and 2 and loads the state.
`timescale 1ns / 1ps
module xorshift128plus_generator_unit import x128p_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] mode, [65:2] range_low, [129:66] range_high, rest zero
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] value
  output logic [63:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata
);
  localparam int ExpW = 6;

  state_t st_r, st_nxt;
  logic [WordW-1:0] seed0_r, seed1_r, s0_r, s1_r, s0_nxt, s1_nxt;
  logic [WordW-1:0] sum_r, low_r, span_r, res_r, res_nxt, mant_r, mant_nxt;
  logic [1:0] mode_r;
  logic [ExpW-1:0] top_r, top_nxt;
  logic [WordW-1:0] a, nb, sum, span;
  logic div_start, div_done;
  logic [WordW-1:0] div_rem;

  assign a = s0_r ^ (s0_r << ShiftA);
  assign nb = a ^ s1_r ^ (a >> ShiftB) ^ (s1_r >> ShiftC);
  assign sum = nb + s1_r;
  assign span = in_tdata[129:66] - in_tdata[65:2] + 64'd1;

  x128p_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r),
    .divisor(span_r), .done(div_done), .remainder(div_rem)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = res_r;
  assign div_start = (st_r == ST_FIN) && (mode_r == ModeRange) && (span_r != '0);

  always_comb begin
    st_nxt = st_r;
    res_nxt = res_r;
    mant_nxt = mant_r;
    top_nxt = top_r;
    case (st_r)
      ST_IDLE: ;
      ST_FIN: begin
        // sum latched; dispatch on mode
        if (mode_r == ModeRange) begin
          if (span_r == '0) begin
            res_nxt = low_r + sum_r;
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_DIV;
          end
        end else if (mode_r == ModeUnit) begin
          mant_nxt = sum_r >> UnitDrop;
          top_nxt = ExpW'(52);
          if ((sum_r >> UnitDrop) == '0) begin
            res_nxt = '0;
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_NORM;
          end
        end else begin
          res_nxt = sum_r;
          st_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt = low_r + div_rem;
          st_nxt = ST_OUT;
        end
      end
      ST_NORM: begin
        if (mant_r[52]) begin
          res_nxt = {1'b0, 11'(1023 - UnitBits) + 11'(top_r), mant_r[51:0]};
          st_nxt = ST_OUT;
        end else begin
          mant_nxt = mant_r << 1;
          top_nxt = top_r - 1'b1;
        end
      end
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (cfg_we) begin
      s0_nxt = (cfg_index == CfgSeedFirst) ? cfg_wdata : seed0_r;
      s1_nxt = (cfg_index == CfgSeedSecond) ? cfg_wdata : seed1_r;
    end else if (in_tvalid && in_tready) begin
      s0_nxt = s1_r;
      s1_nxt = nb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      seed0_r <= SeedFirstRst;
      seed1_r <= SeedSecondRst;
      s0_r <= SeedFirstRst;
      s1_r <= SeedSecondRst;
    end else begin
      st_r <= (in_tvalid && in_tready) ? ST_FIN : st_nxt;
      if (cfg_we && cfg_index == CfgSeedFirst) seed0_r <= cfg_wdata;
      if (cfg_we && cfg_index == CfgSeedSecond) seed1_r <= cfg_wdata;
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
    end
    if (in_tvalid && in_tready) begin
      sum_r <= sum;
      mode_r <= in_tdata[1:0];
      low_r <= in_tdata[65:2];
      span_r <= span;
    end
    res_r <= res_nxt;
    mant_r <= mant_nxt;
    top_r <= top_nxt;
  end
endmodule

@@ rtl/x128p_divider.sv @@
// Radix-2 restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module x128p_divider import x128p_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WordW-1:0] dividend,
  input  logic [WordW-1:0] divisor,
  output logic             done,
  output logic [WordW-1:0] remainder
);
  localparam int CntW = $clog2(WordW + 1);

  logic [WordW-1:0] rem_r, rem_nxt, dvd_r, dvd_nxt, dvs_r, dvs_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [WordW:0]   trial, diff;

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, dvd_r[WordW-1]};
    diff = trial - {1'b0, dvs_r};
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CntW'(WordW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
      dvd_nxt = {dvd_r[WordW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = busy_r && (cnt_r == CntW'(1));
  assign remainder = diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
endmodule
